>>> rtl/core/gbt_pkg.sv
// gbt_pkg: shared types, constants and helper functions for the graph traversal block.
// Used by gbt_ctrl, gbt_dp, graph_bfs_dfs_traversal_top and gbt_checker.
// No dependencies.
`timescale 1ns / 1ps

package gbt_pkg;

	// Graph size and field widths
	localparam int MAX_VERTICES = 64;
	localparam int VW           = 6;   // vertex index width
	localparam int CW           = 7;   // count width (holds MAX_VERTICES itself)
	localparam int ROW_W        = 64;  // adjacency row width
	localparam int WL_W         = 13;  // work list entry: next neighbor [12:6], vertex [5:0]

	// Item actions
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_START = 1'b1;

	// Traversal modes
	localparam logic MODE_BFS = 1'b0;
	localparam logic MODE_DFS = 1'b1;

	// Register indexes (word address)
	localparam logic REG_VERTEX_COUNT = 1'b0;
	localparam logic REG_MODE         = 1'b1;

	typedef struct packed {
		logic             action;
		logic [VW-1:0]    row_index;
		logic [ROW_W-1:0] row_bits;
		logic [VW-1:0]    start_vertex;
	} cmd_item_t;

	typedef struct packed {
		logic [VW-1:0] vertex;
		logic          last;
	} res_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_B_POP,
		ST_B_FETCH,
		ST_B_LOAD,
		ST_B_SCAN,
		ST_D_READ,
		ST_D_SCAN,
		ST_D_RESTORE,
		ST_FLUSH
	} gbt_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;         // write one adjacency row
		logic init;         // start a traversal
		logic bfs_pop;      // read FIFO head
		logic bfs_fetch;    // read row of popped vertex
		logic bfs_load;     // capture candidate set
		logic bfs_emit;     // emit lowest candidate
		logic dfs_read;     // read row of stack top
		logic dfs_emit;     // emit lowest candidate, push it
		logic dfs_pop;      // drop stack top, read new top
		logic dfs_restore;  // load new top from stack memory
		logic flush;        // send held vertex as last
	} gbt_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic start_ok;
		logic mode;
		logic fifo_empty;
		logic cand_zero;
		logic dcand_zero;
		logic depth_one;
		logic can_emit;
		logic pend_valid;
		logic out_free;
	} gbt_status_t;

	// Index of the lowest set bit (0 for an all-zero word)
	function automatic logic [VW-1:0] lowest_set(input logic [ROW_W-1:0] x);
		logic [ROW_W-1:0] iso;
		logic [VW-1:0]    idx;
		iso = x & (~x + ROW_W'(1));
		idx = '0;
		for (int b = 0; b < VW; b++) begin
			for (int k = 0; k < ROW_W; k++) begin
				if (((k >> b) & 1) == 1) begin
					idx[b] = idx[b] | iso[k];
				end
			end
		end
		return idx;
	endfunction

endpackage

>>> rtl/core/graph_bfs_dfs_traversal_top.sv
// graph_bfs_dfs_traversal_top: top level of the graph traversal block; APB register
// file plus controller and datapath. Depends on gbt_pkg, gbt_ctrl, gbt_dp, gbt_ram.
//
// Channel  Direction  Handshake              Word
// cmd      in         cmd_valid / cmd_ready  load row or start traversal
// res      out        res_valid / res_ready  one reached vertex, last flag
// APB      in         psel/penable/pready    vertex_count (0x0), traversal_mode (0x4)
//
// A load word writes one adjacency row. A start word in breadth-first mode pops a
// vertex from the FIFO, fetches its row, captures the candidate set and emits each
// candidate; in depth-first mode it reads the row of the stack top and emits and pushes
// the lowest candidate, or pops the stack and restores the new top. The adjacency and
// work list memories have a registered read. The walk closes by sending the last vertex.
// cmd_ready is high only between traversals. Reset clears control state only;
// adjacency rows must be loaded before use. A stalled res channel stalls the scan.
`timescale 1ns / 1ps

module graph_bfs_dfs_traversal_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  gbt_pkg::cmd_item_t cmd,
	output logic               res_valid,
	input  logic               res_ready,
	output gbt_pkg::res_item_t res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import gbt_pkg::*;

	logic [6:0]  vertex_count_q;
	logic        mode_q;
	logic        reg_wr;
	gbt_cmd_t    dc;
	gbt_status_t st;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= 7'(MAX_VERTICES);
			mode_q         <= MODE_BFS;
		end else if (reg_wr) begin
			unique case (paddr[2])
				REG_VERTEX_COUNT: vertex_count_q <= pwdata[6:0];
				REG_MODE:         mode_q <= pwdata[0];
				default:          mode_q <= mode_q;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (paddr[2])
			REG_VERTEX_COUNT: prdata = {25'd0, vertex_count_q};
			REG_MODE:         prdata = {31'd0, mode_q};
			default:          prdata = '0;
		endcase
	end

	gbt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_action (cmd.action),
		.cmd_ready  (cmd_ready),
		.st         (st),
		.dc         (dc)
	);

	gbt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.vertex_count   (vertex_count_q),
		.traversal_mode (mode_q),
		.dc             (dc),
		.st             (st),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res            (res)
	);

endmodule

>>> rtl/core/gbt_ram.sv
// gbt_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module gbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/gbt_ctrl.sv
// gbt_ctrl: traversal sequencer; issues datapath commands from datapath status.
// Depends on gbt_pkg.
`timescale 1ns / 1ps

module gbt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  logic                 cmd_action,
	output logic                 cmd_ready,
	input  gbt_pkg::gbt_status_t st,
	output gbt_pkg::gbt_cmd_t    dc
);
	import gbt_pkg::*;

	gbt_state_t state_q, state_next;
	logic       accept;

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd_action == ACT_START && st.start_ok) begin
					state_next = (st.mode == MODE_DFS) ? ST_D_READ : ST_B_POP;
				end
			end
			ST_B_POP:   state_next = st.fifo_empty ? ST_FLUSH : ST_B_FETCH;
			ST_B_FETCH: state_next = ST_B_LOAD;
			ST_B_LOAD:  state_next = ST_B_SCAN;
			ST_B_SCAN: begin
				if (st.cand_zero) begin
					state_next = ST_B_POP;
				end
			end
			ST_D_READ:  state_next = ST_D_SCAN;
			ST_D_SCAN: begin
				if (st.dcand_zero) begin
					state_next = st.depth_one ? ST_FLUSH : ST_D_RESTORE;
				end else if (st.can_emit) begin
					state_next = ST_D_READ;
				end
			end
			ST_D_RESTORE: state_next = ST_D_READ;
			ST_FLUSH: begin
				if (!st.pend_valid || st.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Command outputs
	always_comb begin
		dc = '0;
		unique case (state_q)
			ST_IDLE: begin
				dc.load = accept && cmd_action == ACT_LOAD;
				dc.init = accept && cmd_action == ACT_START;
			end
			ST_B_POP:     dc.bfs_pop = !st.fifo_empty;
			ST_B_FETCH:   dc.bfs_fetch = 1'b1;
			ST_B_LOAD:    dc.bfs_load = 1'b1;
			ST_B_SCAN:    dc.bfs_emit = !st.cand_zero && st.can_emit;
			ST_D_READ:    dc.dfs_read = 1'b1;
			ST_D_SCAN: begin
				dc.dfs_pop  = st.dcand_zero && !st.depth_one;
				dc.dfs_emit = !st.dcand_zero && st.can_emit;
			end
			ST_D_RESTORE: dc.dfs_restore = 1'b1;
			ST_FLUSH:     dc.flush = st.pend_valid && st.out_free;
			default:      dc = '0;
		endcase
	end

endmodule

>>> rtl/core/gbt_dp.sv
// gbt_dp: traversal datapath: adjacency and work list memories, visited flags,
// candidate scan, held vertex and output register. Depends on gbt_pkg and gbt_ram.
`timescale 1ns / 1ps

module gbt_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gbt_pkg::cmd_item_t    cmd,
	input  logic [6:0]            vertex_count,
	input  logic                  traversal_mode,
	input  gbt_pkg::gbt_cmd_t     dc,
	output gbt_pkg::gbt_status_t  st,
	output logic                  res_valid,
	input  logic                  res_ready,
	output gbt_pkg::res_item_t    res
);
	import gbt_pkg::*;

	logic [ROW_W-1:0] visited_q, cand_q;
	logic [CW-1:0]    head_q, tail_q, depth_q;
	logic [VW-1:0]    top_v_q;
	logic [CW-1:0]    top_from_q;
	logic             pend_valid_q;
	logic [VW-1:0]    pend_v_q;
	logic             out_valid_q;
	res_item_t        out_q;

	logic [CW-1:0]    n_eff;
	logic [ROW_W-1:0] live, from_mask, dcand;
	logic [VW-1:0]    next_b, next_d, emit_v;
	logic             emit_any, out_free, start_ok;
	logic [CW-1:0]    depth_m1, depth_m2, next_d_p1;

	logic             adj_re;
	logic [VW-1:0]    adj_raddr;
	logic [ROW_W-1:0] adj_rdata;
	logic             wl_we, wl_re;
	logic [VW-1:0]    wl_waddr, wl_raddr;
	logic [WL_W-1:0]  wl_wdata, wl_rdata;

	// Active vertex count and live mask
	always_comb begin
		if (vertex_count == '0) begin
			n_eff = CW'(1);
		end else if (vertex_count > CW'(MAX_VERTICES)) begin
			n_eff = CW'(MAX_VERTICES);
		end else begin
			n_eff = vertex_count;
		end
		if (n_eff >= CW'(ROW_W)) begin
			live = '1;
		end else begin
			live = (ROW_W'(1) << n_eff) - ROW_W'(1);
		end
	end

	assign start_ok = {1'b0, cmd.start_vertex} < n_eff;

	// Candidate selection
	assign from_mask = (top_from_q >= CW'(ROW_W)) ? '0 : ('1 << top_from_q);
	assign dcand     = adj_rdata & live & ~visited_q & from_mask;
	assign next_b    = lowest_set(cand_q);
	assign next_d    = lowest_set(dcand);
	assign next_d_p1 = {1'b0, next_d} + CW'(1);
	assign depth_m1  = depth_q - CW'(1);
	assign depth_m2  = depth_q - CW'(2);

	// Emission source
	assign emit_any = (dc.init && start_ok) || dc.bfs_emit || dc.dfs_emit;
	always_comb begin
		if (dc.init) begin
			emit_v = cmd.start_vertex;
		end else if (dc.bfs_emit) begin
			emit_v = next_b;
		end else begin
			emit_v = next_d;
		end
	end

	assign out_free = !out_valid_q || res_ready;

	// Adjacency memory
	assign adj_re    = dc.bfs_fetch || dc.dfs_read;
	assign adj_raddr = dc.dfs_read ? top_v_q : wl_rdata[VW-1:0];

	gbt_ram #(.WIDTH(ROW_W), .DEPTH(MAX_VERTICES)) u_adj_ram (
		.clk   (clk),
		.we    (dc.load),
		.waddr (cmd.row_index),
		.wdata (cmd.row_bits),
		.re    (adj_re),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	// Work list memory: FIFO in breadth-first, stack below the cached top in depth-first
	always_comb begin
		wl_we    = 1'b0;
		wl_waddr = '0;
		wl_wdata = '0;
		if (dc.init) begin
			wl_we    = start_ok;
			wl_wdata = {{(WL_W-VW){1'b0}}, cmd.start_vertex};
		end else if (dc.bfs_emit) begin
			wl_we    = tail_q < CW'(MAX_VERTICES);
			wl_waddr = tail_q[VW-1:0];
			wl_wdata = {{(WL_W-VW){1'b0}}, next_b};
		end else if (dc.dfs_emit) begin
			wl_we    = depth_q < CW'(MAX_VERTICES);
			wl_waddr = depth_m1[VW-1:0];
			wl_wdata = {next_d_p1, top_v_q};
		end
	end

	assign wl_re    = dc.bfs_pop || dc.dfs_pop;
	assign wl_raddr = dc.bfs_pop ? head_q[VW-1:0] : depth_m2[VW-1:0];

	gbt_ram #(.WIDTH(WL_W), .DEPTH(MAX_VERTICES)) u_wl_ram (
		.clk   (clk),
		.we    (wl_we),
		.waddr (wl_waddr),
		.wdata (wl_wdata),
		.re    (wl_re),
		.raddr (wl_raddr),
		.rdata (wl_rdata)
	);

	// Control registers: visited flags, list pointers, held and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q    <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			depth_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (dc.init) begin
				visited_q <= start_ok ? (ROW_W'(1) << cmd.start_vertex) : '0;
				head_q    <= '0;
				tail_q    <= start_ok ? CW'(1) : '0;
				depth_q   <= start_ok ? CW'(1) : '0;
			end
			if (dc.bfs_pop) begin
				head_q <= head_q + CW'(1);
			end
			if (dc.bfs_emit) begin
				visited_q <= visited_q | (ROW_W'(1) << next_b);
				if (tail_q < CW'(MAX_VERTICES)) begin
					tail_q <= tail_q + CW'(1);
				end
			end
			if (dc.dfs_emit) begin
				visited_q <= visited_q | (ROW_W'(1) << next_d);
				if (depth_q < CW'(MAX_VERTICES)) begin
					depth_q <= depth_q + CW'(1);
				end
			end
			if (dc.dfs_pop) begin
				depth_q <= depth_m1;
			end
			// held vertex
			if (emit_any) begin
				pend_valid_q <= 1'b1;
			end else if (dc.flush) begin
				pend_valid_q <= 1'b0;
			end
			// output register
			if ((emit_any && pend_valid_q) || dc.flush) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (dc.init) begin
			top_v_q    <= cmd.start_vertex;
			top_from_q <= '0;
		end
		if (dc.bfs_load) begin
			cand_q <= adj_rdata & live & ~visited_q;
		end else if (dc.bfs_emit) begin
			cand_q <= cand_q & (cand_q - ROW_W'(1));
		end
		if (dc.dfs_emit) begin
			if (depth_q < CW'(MAX_VERTICES)) begin
				top_v_q    <= next_d;
				top_from_q <= '0;
			end else begin
				top_from_q <= next_d_p1;
			end
		end
		if (dc.dfs_restore) begin
			top_v_q    <= wl_rdata[VW-1:0];
			top_from_q <= wl_rdata[WL_W-1:VW];
		end
		if (emit_any) begin
			pend_v_q <= emit_v;
		end
		if (emit_any && pend_valid_q) begin
			out_q <= '{vertex: pend_v_q, last: 1'b0};
		end else if (dc.flush) begin
			out_q <= '{vertex: pend_v_q, last: 1'b1};
		end
	end

	// Status to controller
	always_comb begin
		st            = '0;
		st.start_ok   = start_ok;
		st.mode       = traversal_mode;
		st.fifo_empty = head_q == tail_q;
		st.cand_zero  = cand_q == '0;
		st.dcand_zero = dcand == '0;
		st.depth_one  = depth_q == CW'(1);
		st.can_emit   = !pend_valid_q || out_free;
		st.pend_valid = pend_valid_q;
		st.out_free   = out_free;
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

>>> rtl/core/gbt_checker.sv
// gbt_checker: port-level assertions for the graph traversal block, bound to the top.
// Depends on gbt_pkg and graph_bfs_dfs_traversal_top.
`timescale 1ns / 1ps

module gbt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_ready,
	input gbt_pkg::cmd_item_t cmd,
	input logic               res_valid,
	input logic               res_ready,
	input gbt_pkg::res_item_t res,
	input logic               pready
);
	import gbt_pkg::*;

	// A stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	// A non-final vertex is only shown while a traversal is running
	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> !cmd_ready)
		else $error("block idle with a traversal still open");

	// A load word never leaves the idle state
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd.action == ACT_LOAD |=> cmd_ready)
		else $error("load word made the block busy");

	// Register port never stalls
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind graph_bfs_dfs_traversal_top gbt_checker u_gbt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd       (cmd),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res),
	.pready    (pready)
);
